// File: rtl/ip_address_routability_check_defines.svh
// Assertion macros shared by the routability check RTL.
`ifndef IP_ADDRESS_ROUTABILITY_CHECK_DEFINES_SVH
`define IP_ADDRESS_ROUTABILITY_CHECK_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define IPARC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("routability check: property violated");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define IPARC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("routability check: property violated");

`endif

// File: rtl/iparc_pkg.sv
// Types and constants shared by the routability check modules.
package iparc_pkg;

    // Address kind codes; codes 6 and 7 are unassigned.
    localparam logic [2:0] KIND_IPV4   = 3'd0;
    localparam logic [2:0] KIND_IPV6   = 3'd1;
    localparam logic [2:0] KIND_TOR_V3 = 3'd2;
    localparam logic [2:0] KIND_DNS    = 3'd3;
    localparam logic [2:0] KIND_WS     = 3'd4;
    localparam logic [2:0] KIND_TOR_V2 = 3'd5;

    localparam int unsigned ADDR_BYTES = 16;

    // IPv6 prefix bytes.
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_ONES    = 8'hFF;
    localparam logic [7:0] NAT64_B1     = 8'h64;
    localparam logic [7:0] NAT64_B3     = 8'h9B;
    localparam logic [7:0] V6_2X_B0     = 8'h20;
    localparam logic [7:0] SIX2FOUR_B1  = 8'h02;
    localparam logic [7:0] V6_2001_B1   = 8'h01;
    localparam logic [7:0] DOC_B2       = 8'h0D;
    localparam logic [7:0] DOC_B3       = 8'hB8;
    localparam logic [7:0] LLOCAL_B0    = 8'hFE;
    localparam logic [7:0] LLOCAL_B1    = 8'h80;
    localparam logic [7:0] ULA_MASK     = 8'hFE;
    localparam logic [7:0] ULA_B0       = 8'hFC;
    localparam logic [7:0] ORCHID_MASK  = 8'hF0;
    localparam logic [7:0] ORCHID_B3    = 8'h10;

    // IPv4 octet values.
    localparam logic [7:0] V4_LOOP      = 8'd127;
    localparam logic [7:0] V4_ZERO      = 8'd0;
    localparam logic [7:0] V4_ONES      = 8'd255;
    localparam logic [7:0] V4_TEN       = 8'd10;
    localparam logic [7:0] V4_172       = 8'd172;
    localparam logic [7:0] V4_192       = 8'd192;
    localparam logic [7:0] V4_168       = 8'd168;
    localparam logic [7:0] V4_198       = 8'd198;
    localparam logic [7:0] V4_169       = 8'd169;
    localparam logic [7:0] V4_254       = 8'd254;
    localparam logic [7:0] V4_100       = 8'd100;
    localparam logic [7:0] V4_203       = 8'd203;

    // Decoded view of one address handed from unwrap to judge.
    typedef struct packed {
        logic       use_v4;
        logic [7:0] oct_a;
        logic [7:0] oct_b;
        logic [7:0] oct_c;
        logic [7:0] oct_d;
        logic       v6_loop;
        logic       v6_bad;
    } addr_info_t;

endpackage

// File: rtl/iparc_unwrap.sv
// Address unwrap: finds embedded IPv4 forms and flags reserved IPv6 ranges.
module iparc_unwrap (
    input  logic [2:0]               addr_kind,
    input  logic [63:0]              addr_bytes_upper,
    input  logic [63:0]              addr_bytes_lower,
    output iparc_pkg::addr_info_t    info
);
    import iparc_pkg::*;

    logic [7:0] b [ADDR_BYTES];
    logic       zero_0_8;
    logic       zero_8_10;
    logic       zero_4_8;
    logic       zero_8_12;
    logic       zero_12_15;
    logic       zero_2_8;
    logic       is_mapped;
    logic       is_nat64;
    logic       is_siit;
    logic       is_6to4;
    logic       embed_12;
    logic       v6_zero;
    logic       v6_doc;
    logic       v6_llocal;
    logic       v6_ula;
    logic       v6_orchid;

    // Split the two words into bytes, byte 0 most significant.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            b[i]     = addr_bytes_upper[63 - 8*i -: 8];
            b[i + 8] = addr_bytes_lower[63 - 8*i -: 8];
        end
    end

    // Zero tests over byte ranges.
    assign zero_0_8   = (addr_bytes_upper == 64'd0);
    assign zero_2_8   = (addr_bytes_upper[47:0] == 48'd0);
    assign zero_4_8   = (addr_bytes_upper[31:0] == 32'd0);
    assign zero_8_10  = (addr_bytes_lower[63:48] == 16'd0);
    assign zero_8_12  = (addr_bytes_lower[63:32] == 32'd0);
    assign zero_12_15 = (addr_bytes_lower[31:8] == 24'd0);

    // Embedding IPv6 forms.
    assign is_mapped = zero_0_8 && zero_8_10 && (b[10] == BYTE_ONES) && (b[11] == BYTE_ONES);
    assign is_nat64  = (b[0] == BYTE_ZERO) && (b[1] == NAT64_B1) && (b[2] == BYTE_ONES)
                       && (b[3] == NAT64_B3) && zero_4_8 && zero_8_12;
    assign is_siit   = zero_0_8 && (b[8] == BYTE_ONES) && (b[9] == BYTE_ONES)
                       && (b[10] == BYTE_ZERO) && (b[11] == BYTE_ZERO);
    assign is_6to4   = (b[0] == V6_2X_B0) && (b[1] == SIX2FOUR_B1);
    assign embed_12  = is_mapped || is_nat64 || is_siit;

    // Reserved native IPv6 ranges.
    assign v6_zero   = zero_0_8 && zero_8_12 && zero_12_15 && (b[15] == BYTE_ZERO);
    assign v6_doc    = (b[0] == V6_2X_B0) && (b[1] == V6_2001_B1) && (b[2] == DOC_B2)
                       && (b[3] == DOC_B3);
    assign v6_llocal = (b[0] == LLOCAL_B0) && (b[1] == LLOCAL_B1) && zero_2_8;
    assign v6_ula    = ((b[0] & ULA_MASK) == ULA_B0);
    assign v6_orchid = (b[0] == V6_2X_B0) && (b[1] == V6_2001_B1) && (b[2] == BYTE_ZERO)
                       && ((b[3] & ORCHID_MASK) == ORCHID_B3);

    // Pick the octets that the IPv4 rules will see.
    always_comb
    begin
        info.v6_loop = zero_0_8 && zero_8_12 && zero_12_15 && (b[15] == 8'd1);
        info.v6_bad  = v6_zero || v6_doc || v6_llocal || v6_ula || v6_orchid;
        info.use_v4  = (addr_kind == KIND_IPV4)
                       || ((addr_kind == KIND_IPV6) && (embed_12 || is_6to4));
        if (addr_kind == KIND_IPV4)
        begin
            info.oct_a = b[0];
            info.oct_b = b[1];
            info.oct_c = b[2];
            info.oct_d = b[3];
        end
        else if (is_6to4)
        begin
            info.oct_a = b[2];
            info.oct_b = b[3];
            info.oct_c = b[4];
            info.oct_d = b[5];
        end
        else
        begin
            info.oct_a = b[12];
            info.oct_b = b[13];
            info.oct_c = b[14];
            info.oct_d = b[15];
        end
    end

endmodule

// File: rtl/iparc_judge.sv
// Final judgment: applies IPv4 rules or IPv6 flags and the kind decode.
module iparc_judge (
    input  logic [2:0]            addr_kind,
    input  logic                  allow_loopback,
    input  iparc_pkg::addr_info_t info,
    output logic                  routable
);
    import iparc_pkg::*;

    logic v4_loop;
    logic v4_bad;
    logic v4_ok;
    logic v6_ok;
    logic ip_ok;

    // IPv4 loopback and reserved ranges.
    always_comb
    begin
        v4_loop = (info.oct_a == V4_LOOP) || (info.oct_a == V4_ZERO);
        v4_bad  = ((info.oct_a == V4_ONES) && (info.oct_b == V4_ONES)
                   && (info.oct_c == V4_ONES) && (info.oct_d == V4_ONES))
               || ((info.oct_a == V4_ZERO) && (info.oct_b == V4_ZERO)
                   && (info.oct_c == V4_ZERO) && (info.oct_d == V4_ZERO))
               || (info.oct_a == V4_TEN)
               || ((info.oct_a == V4_192) && (info.oct_b == V4_168))
               || ((info.oct_a == V4_172) && (info.oct_b[7:4] == 4'h1))
               || ((info.oct_a == V4_198) && (info.oct_b[7:1] == 7'd9))
               || ((info.oct_a == V4_169) && (info.oct_b == V4_254))
               || ((info.oct_a == V4_100) && (info.oct_b[7:6] == 2'b01))
               || ((info.oct_a == V4_192) && (info.oct_b == 8'd0) && (info.oct_c == 8'd2))
               || ((info.oct_a == V4_198) && (info.oct_b == 8'd51) && (info.oct_c == 8'd100))
               || ((info.oct_a == V4_203) && (info.oct_b == 8'd0) && (info.oct_c == 8'd113))
               || v4_loop;
        v4_ok   = (allow_loopback && v4_loop) || !v4_bad;
        v6_ok   = (allow_loopback && info.v6_loop) || !(info.v6_bad || info.v6_loop);
        ip_ok   = info.use_v4 ? v4_ok : v6_ok;
    end

    // Kind decode: IP kinds take the check, other known kinds always pass.
    always_comb
    begin
        unique case (addr_kind)
            KIND_IPV4, KIND_IPV6:                       routable = ip_ok;
            KIND_TOR_V3, KIND_DNS, KIND_WS, KIND_TOR_V2: routable = 1'b1;
            default:                                    routable = 1'b0;
        endcase
    end

endmodule

// File: rtl/ip_address_routability_check.sv
// Top level of the address routability check: request and result registers.
//
// Channel   Direction  Handshake         Payload
// request   in         start, busy       addr_kind, addr_bytes_upper, addr_bytes_lower,
//                                         allow_loopback
// result    out        done              is_routable
//
// A request can be taken in every cycle that start is high; busy is always low.
// A taken request is captured in the request register; the unwrap and judge logic
// then load the result register from it, which raises done with the result.
// rst_n clears the valid flags of both registers at once.
// The result is shown for one cycle with done high; is_routable then holds it.

`include "ip_address_routability_check_defines.svh"

module ip_address_routability_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  addr_kind,
    input  logic [63:0] addr_bytes_upper,
    input  logic [63:0] addr_bytes_lower,
    input  logic        allow_loopback,
    output logic        done,
    output logic        is_routable
);
    import iparc_pkg::*;

    logic        accept;
    logic        in_vld_reg;
    logic [2:0]  kind_reg;
    logic [63:0] upper_reg;
    logic [63:0] lower_reg;
    logic        allow_reg;
    logic        done_reg;
    logic        routable_reg;
    logic        routable_next;
    addr_info_t  info;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Request register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
        end
    end

    // Request payload capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= addr_kind;
            upper_reg <= addr_bytes_upper;
            lower_reg <= addr_bytes_lower;
            allow_reg <= allow_loopback;
        end
    end

    iparc_unwrap u_unwrap (
        .addr_kind        (kind_reg),
        .addr_bytes_upper (upper_reg),
        .addr_bytes_lower (lower_reg),
        .info             (info)
    );

    iparc_judge u_judge (
        .addr_kind      (kind_reg),
        .allow_loopback (allow_reg),
        .info           (info),
        .routable       (routable_next)
    );

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_vld_reg;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_vld_reg)
        begin
            routable_reg <= routable_next;
        end
    end

    assign done        = done_reg;
    assign is_routable = routable_reg;

    // Every taken request reaches the request register, then the result strobe.
    `IPARC_ASSERT_NEXT(a_accept_to_stage, accept, in_vld_reg)
    `IPARC_ASSERT_NEXT(a_stage_to_done, in_vld_reg, done_reg)
    // No result without a request in flight.
    `IPARC_ASSERT_NEXT(a_no_spurious_done, !in_vld_reg, !done_reg)
    // Non-IP kinds always come out routable.
    `IPARC_ASSERT_NEXT(a_nonip_routable,
        in_vld_reg && (kind_reg == KIND_TOR_V3 || kind_reg == KIND_DNS
                       || kind_reg == KIND_WS || kind_reg == KIND_TOR_V2),
        done_reg && routable_reg)

endmodule

// File: verif/ip_address_routability_check_test.sv
// Self-checking testbench for the address routability check: directed table, then random.
`timescale 1ns / 1ps

module ip_address_routability_check_test;

    import iparc_pkg::*;

    // Kind codes that the block leaves unassigned.
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    // One row of the directed table; a typed row carries its own answer.
    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] upper;
        logic [63:0] lower;
        logic        allow;
        logic        typed;
        logic        routable;
    } probe_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  addr_kind;
    logic [63:0] addr_bytes_upper;
    logic [63:0] addr_bytes_lower;
    logic        allow_loopback;
    logic        done;
    logic        is_routable;

    // Side-band for the monitor: the typed answer of the request on the ports.
    logic        req_typed;
    logic        req_routable;

    logic        routable_expected_q[$];
    int unsigned error_count;
    probe_row_t  directed_rows[$];

    ip_address_routability_check i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .addr_kind        (addr_kind),
        .addr_bytes_upper (addr_bytes_upper),
        .addr_bytes_lower (addr_bytes_lower),
        .allow_loopback   (allow_loopback),
        .done             (done),
        .is_routable      (is_routable)
    );

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // IPv4 judgement on four octets.
    function automatic logic v4_public(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d,
                                       input logic allow);
        logic loop;
        loop = (a == 8'd127) || (a == 8'd0);
        if (allow && loop)
            return 1'b1;
        if ({a, b, c, d} == 32'hFFFF_FFFF || {a, b, c, d} == 32'h0)
            return 1'b0;
        if (a == 8'd10)
            return 1'b0;
        if (a == 8'd192 && b == 8'd168)
            return 1'b0;
        if (a == 8'd172 && b >= 8'd16 && b <= 8'd31)
            return 1'b0;
        if (a == 8'd198 && (b == 8'd18 || b == 8'd19))
            return 1'b0;
        if (a == 8'd169 && b == 8'd254)
            return 1'b0;
        if (a == 8'd100 && b >= 8'd64 && b <= 8'd127)
            return 1'b0;
        if (a == 8'd192 && b == 8'd0 && c == 8'd2)
            return 1'b0;
        if (a == 8'd198 && b == 8'd51 && c == 8'd100)
            return 1'b0;
        if (a == 8'd203 && b == 8'd0 && c == 8'd113)
            return 1'b0;
        return !loop;
    endfunction

    // Native IPv6 judgement on the whole 128-bit address.
    function automatic logic v6_public(input logic [127:0] addr, input logic allow);
        logic loop;
        loop = (addr == 128'h1);
        if (allow && loop)
            return 1'b1;
        if (addr == 128'h0)
            return 1'b0;
        if (addr[127:96] == 32'h2001_0DB8)
            return 1'b0;
        if (addr[127:112] == 16'hFE80 && addr[111:64] == 48'h0)
            return 1'b0;
        if ((addr[127:120] & 8'hFE) == 8'hFC)
            return 1'b0;
        if (addr[127:104] == 24'h20_0100 && (addr[103:96] & 8'hF0) == 8'h10)
            return 1'b0;
        return !loop;
    endfunction

    // Expected routable bit for one request.
    function automatic logic routability_of(input logic [2:0] kind, input logic [63:0] upper,
                                            input logic [63:0] lower, input logic allow);
        logic [127:0] addr;
        logic [31:0]  v4;
        logic         embedded;
        addr     = {upper, lower};
        embedded = 1'b1;
        if (addr[127:48] == 80'h0 && addr[47:32] == 16'hFFFF)
            v4 = addr[31:0];
        else if (addr[127:96] == 32'h0064_FF9B && addr[95:32] == 64'h0)
            v4 = addr[31:0];
        else if (addr[127:64] == 64'h0 && addr[63:32] == 32'hFFFF_0000)
            v4 = addr[31:0];
        else if (addr[127:112] == 16'h2002)
            v4 = addr[111:80];
        else
        begin
            v4       = 32'h0;
            embedded = 1'b0;
        end
        case (kind)
            KIND_IPV4:
                return v4_public(upper[63:56], upper[55:48], upper[47:40], upper[39:32], allow);
            KIND_IPV6:
                if (embedded)
                    return v4_public(v4[31:24], v4[23:16], v4[15:8], v4[7:0], allow);
                else
                    return v6_public(addr, allow);
            KIND_TOR_V3, KIND_DNS, KIND_WS, KIND_TOR_V2:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic probe_row_t probe(input logic [2:0] kind, input logic [63:0] upper,
                                         input logic [63:0] lower, input logic allow,
                                         input logic typed, input logic routable);
        probe_row_t r;
        r.kind     = kind;
        r.upper    = upper;
        r.lower    = lower;
        r.allow    = allow;
        r.typed    = typed;
        r.routable = routable;
        return r;
    endfunction

    // First IPv4 octet, weighted toward the values that open a reserved range.
    function automatic logic [7:0] pick_first_octet();
        case ($urandom_range(0, 11))
            0: return 8'd0;
            1: return 8'd10;
            2: return 8'd100;
            3: return 8'd127;
            4: return 8'd169;
            5: return 8'd172;
            6: return 8'd192;
            7: return 8'd198;
            8: return 8'd203;
            9: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Second octet, weighted toward range borders.
    function automatic logic [7:0] pick_second_octet();
        case ($urandom_range(0, 15))
            0: return 8'd0;
            1: return 8'd15;
            2: return 8'd16;
            3: return 8'd31;
            4: return 8'd32;
            5: return 8'd18;
            6: return 8'd19;
            7: return 8'd51;
            8: return 8'd63;
            9: return 8'd64;
            10: return 8'd127;
            11: return 8'd168;
            12: return 8'd254;
            13: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_v4();
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        a = pick_first_octet();
        b = pick_second_octet();
        case ($urandom_range(0, 5))
            0: c = 8'd2;
            1: c = 8'd100;
            2: c = 8'd113;
            3: c = 8'd255;
            default: c = 8'($urandom);
        endcase
        d = ($urandom_range(0, 5) == 0) ? a : 8'($urandom);
        return {a, b, c, d};
    endfunction

    // Put one request on the ports and hold it until the block takes it.
    task automatic issue_request(input probe_row_t r);
        start            <= 1'b1;
        addr_kind        <= r.kind;
        addr_bytes_upper <= r.upper;
        addr_bytes_lower <= r.lower;
        allow_loopback   <= r.allow;
        req_typed        <= r.typed;
        req_routable     <= r.routable;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Idle the request side for a random gap after a taken request.
    task automatic idle_after_request(input logic burst);
        int unsigned roll;
        int unsigned gap;
        roll = $urandom_range(0, 99);
        if (burst || roll < 60)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result checking and expectation capture on each rising edge.
    always @(posedge clk)
    begin
        logic want;
        if (rst_n)
        begin
            if (done)
            begin
                if (routable_expected_q.size() == 0)
                begin
                    $error("is_routable: no request outstanding, actual %0b", is_routable);
                    error_count++;
                end
                else
                begin
                    want = routable_expected_q.pop_front();
                    if (is_routable !== want)
                    begin
                        $error("is_routable: expected %0b, actual %0b", want, is_routable);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (req_typed)
                    routable_expected_q.push_back(req_routable);
                else
                    routable_expected_q.push_back(routability_of(addr_kind, addr_bytes_upper,
                                                                 addr_bytes_lower,
                                                                 allow_loopback));
            end
        end
    end

    // Stimulus: directed table, then random requests.
    initial
    begin
        probe_row_t   r;
        logic [127:0] addr;
        logic         burst;
        int unsigned  roll;
        int unsigned  k;

        error_count      = 0;
        rst_n            = 1'b0;
        start            = 1'b0;
        addr_kind        = KIND_IPV4;
        addr_bytes_upper = 64'h0;
        addr_bytes_lower = 64'h0;
        allow_loopback   = 1'b0;
        req_typed        = 1'b0;
        req_routable     = 1'b0;

        // IPv4 extremes, loopback and every reserved range.
        directed_rows.push_back(probe(KIND_IPV4, 64'h0808_0808_0000_0000, 64'h0, 1'b0, 1'b1, 1'b1));
        directed_rows.push_back(probe(KIND_IPV4, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                      1'b1, 1'b1, 1'b0));
        directed_rows.push_back(probe(KIND_IPV4, 64'h0, 64'h0, 1'b0, 1'b1, 1'b0));
        directed_rows.push_back(probe(KIND_IPV4, 64'h0, 64'h0, 1'b1, 1'b1, 1'b1));
        directed_rows.push_back(probe(KIND_IPV4, 64'h7F00_0001_0000_0000, 64'h0, 1'b0, 1'b1, 1'b0));
        directed_rows.push_back(probe(KIND_IPV4, 64'h7F00_0001_0000_0000, 64'h0, 1'b1, 1'b1, 1'b1));
        directed_rows.push_back(probe(KIND_IPV4, 64'h0AFF_FFFF_0000_0000, 64'h0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV4, 64'hAC1F_0001_0000_0000, 64'h0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV4, 64'hC0A8_0101_0000_0000, 64'h0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV4, 64'hC613_0001_0000_0000, 64'h0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV4, 64'hA9FE_0101_0000_0000, 64'h0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV4, 64'h6440_0001_0000_0000, 64'h0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV4, 64'hC000_0201_0000_0000, 64'h0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV4, 64'hC633_6401_0000_0000, 64'h0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV4, 64'hCB00_7105_0000_0000, 64'h0, 1'b0, 1'b0, 1'b0));
        // Native IPv6: unspecified, loopback, documentation, link-local, ULA, ORCHID.
        directed_rows.push_back(probe(KIND_IPV6, 64'h0, 64'h0, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(probe(KIND_IPV6, 64'h0, 64'h1, 1'b1, 1'b1, 1'b1));
        directed_rows.push_back(probe(KIND_IPV6, 64'h2001_0DB8_0000_0000, 64'h1, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV6, 64'hFE80_0000_0000_0000, 64'h5, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV6, 64'hFD12_3456_789A_0000, 64'h1, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV6, 64'h2001_001F_0000_0000, 64'h1, 1'b0, 1'b0, 1'b0));
        // IPv6 forms carrying an IPv4 address: mapped, NAT64, SIIT and 6to4.
        directed_rows.push_back(probe(KIND_IPV6, 64'h0, 64'h0000_FFFF_7F00_0001, 1'b1, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV6, 64'h0064_FF9B_0000_0000, 64'h0000_0000_CB00_7109,
                                      1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV6, 64'h0, 64'hFFFF_0000_0808_0808, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(probe(KIND_IPV6, 64'h2002_C0A8_0101_0000, 64'h0, 1'b0, 1'b0, 1'b0));
        // Non-IP kinds pass; unassigned kinds fail.
        directed_rows.push_back(probe(KIND_TOR_V3, 64'h0, 64'h0, 1'b0, 1'b1, 1'b1));
        directed_rows.push_back(probe(KIND_DNS, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b1, 1'b1));
        directed_rows.push_back(probe(KIND_WS, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1));
        directed_rows.push_back(probe(KIND_TOR_V2, 64'h0A00_0001_0000_0000, 64'h0, 1'b0, 1'b1, 1'b1));
        directed_rows.push_back(probe(KIND_SPARE_6, 64'h0808_0808_0000_0000, 64'h0, 1'b0, 1'b1,
                                      1'b0));
        directed_rows.push_back(probe(KIND_SPARE_7, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 1'b1,
                                      1'b0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            issue_request(directed_rows[i]);
            idle_after_request(1'b0);
        end

        // Random requests, mostly well-formed addresses near range borders.
        burst = 1'b0;
        for (int n = 0; n < 620; n++)
        begin
            if (n % 80 == 0)
                burst = ($urandom_range(0, 1) == 1);
            roll    = $urandom_range(0, 99);
            addr    = {$urandom, $urandom, $urandom, $urandom};
            r.kind  = KIND_IPV6;
            r.allow = 1'($urandom_range(0, 1));
            r.typed = 1'b0;
            r.routable = 1'b0;
            if (roll < 30)
            begin
                r.kind = KIND_IPV4;
                addr[127:96] = pick_v4();
            end
            else if (roll < 50)
            begin
                case ($urandom_range(0, 3))
                    0: addr = {80'h0, 16'hFFFF, pick_v4()};
                    1: addr = {32'h0064_FF9B, 64'h0, pick_v4()};
                    2: addr = {64'h0, 32'hFFFF_0000, pick_v4()};
                    default: addr = {16'h2002, pick_v4(), addr[79:0]};
                endcase
            end
            else if (roll < 70)
            begin
                case ($urandom_range(0, 6))
                    0: addr = 128'h0;
                    1: addr = 128'h1;
                    2: addr[127:96] = 32'h2001_0DB8;
                    3: addr[127:64] = 64'hFE80_0000_0000_0000;
                    4: addr[127:112] = 16'hFE80;
                    5: addr[127:121] = 7'b1111_110;
                    default: addr[127:100] = 28'h2001_001;
                endcase
            end
            else if (roll < 85)
                r.kind = KIND_IPV6;
            else if (roll < 95)
                r.kind = 3'($urandom_range(KIND_TOR_V3, KIND_TOR_V2));
            else
                r.kind = ($urandom_range(0, 1) == 1) ? KIND_SPARE_7 : KIND_SPARE_6;
            // Near misses: one flipped bit in the upper 96 bits of an IPv6 address.
            if (r.kind == KIND_IPV6 && roll >= 30 && roll < 70 && $urandom_range(0, 6) == 0)
            begin
                k = $urandom_range(32, 127);
                addr[k] = !addr[k];
            end
            r.upper = addr[127:64];
            r.lower = addr[63:0];
            issue_request(r);
            idle_after_request(burst);
        end

        start <= 1'b0;
        @(posedge clk);
        while (routable_expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
